// File: rtl/gpioid_pkg.sv
// ----------------------------------------------------------------------------
// gpioid_pkg
// Shared types and constants for the GPIO port with interrupt detection.
// ----------------------------------------------------------------------------
package gpioid_pkg;

    localparam int PIN_WIDTH = 32;
    localparam int CNT_W     = 6;

    localparam logic [PIN_WIDTH-1:0] PIN_MASK = {PIN_WIDTH{1'b1}};

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_WRITE = 2'd2;

    localparam logic [4:0] REG_DIR     = 5'd0;
    localparam logic [4:0] REG_PINS    = 5'd1;
    localparam logic [4:0] REG_SET     = 5'd2;
    localparam logic [4:0] REG_CLR     = 5'd3;
    localparam logic [4:0] REG_MODE_LO = 5'd5;
    localparam logic [4:0] REG_MODE_HI = 5'd6;
    localparam logic [4:0] REG_MASK    = 5'd7;
    localparam logic [4:0] REG_STATUS  = 5'd14;

    localparam logic [1:0] MODE_LEVEL_HIGH = 2'd0;
    localparam logic [1:0] MODE_LEVEL_LOW  = 2'd1;
    localparam logic [1:0] MODE_RISE       = 2'd2;
    localparam logic [1:0] MODE_FALL       = 2'd3;

    typedef struct packed {
        logic [1:0]  action;
        logic [4:0]  reg_index;
        logic [31:0] write_data;
        logic [31:0] pin_levels;
    } in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [31:0] out_values;
        logic [31:0] out_enables;
        logic        irq;
    } out_t;

endpackage

// File: rtl/gpioid_core.sv
// ----------------------------------------------------------------------------
// gpioid_core
// Register file, edge/level detection and result formation for one transfer.
// ----------------------------------------------------------------------------
module gpioid_core
    import gpioid_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    input  logic             accept,
    input  in_t              item,
    output out_t             result
);

    logic [CNT_W-1:0]     pin_count_reg;
    logic [PIN_WIDTH-1:0] dir_reg, dir_next;
    logic [PIN_WIDTH-1:0] latch_reg, latch_next;
    logic [31:0]          mode_lo_reg, mode_lo_next;
    logic [31:0]          mode_hi_reg, mode_hi_next;
    logic [PIN_WIDTH-1:0] mask_reg, mask_next;
    logic [PIN_WIDTH-1:0] status_reg, status_next;
    logic [PIN_WIDTH-1:0] prev_reg, prev_next;

    logic [PIN_WIDTH-1:0] valid_pins;
    logic [PIN_WIDTH-1:0] events;
    logic [PIN_WIDTH-1:0] levels;
    logic [PIN_WIDTH-1:0] wdata;
    logic [63:0]          modes;
    logic [1:0]           mode;
    logic [31:0]          rdata;

    assign levels = item.pin_levels[PIN_WIDTH-1:0];
    assign wdata  = item.write_data[PIN_WIDTH-1:0];
    assign modes  = {mode_hi_reg, mode_lo_reg};

    always_comb begin
        for (int i = 0; i < PIN_WIDTH; i++) begin
            valid_pins[i] = (CNT_W'(i) < pin_count_reg);
        end
    end

    always_comb begin
        events = '0;
        for (int i = 0; i < PIN_WIDTH; i++) begin
            mode = modes[2*i +: 2];
            case (mode)
                MODE_LEVEL_HIGH: events[i] = levels[i];
                MODE_LEVEL_LOW:  events[i] = ~levels[i];
                MODE_RISE:       events[i] = levels[i] & ~prev_reg[i];
                default:         events[i] = ~levels[i] & prev_reg[i];
            endcase
        end
    end

    always_comb begin
        dir_next     = dir_reg;
        latch_next   = latch_reg;
        mode_lo_next = mode_lo_reg;
        mode_hi_next = mode_hi_reg;
        mask_next    = mask_reg;
        status_next  = status_reg;
        prev_next    = prev_reg;
        rdata        = '0;
        unique case (item.action)
            ACT_TICK: begin
                status_next = status_reg | (events & valid_pins);
                prev_next   = levels;
            end
            ACT_READ: begin
                unique case (item.reg_index)
                    REG_DIR:           rdata = 32'(dir_reg);
                    REG_PINS:          rdata = 32'((levels & dir_reg) | (latch_reg & ~dir_reg));
                    REG_SET, REG_CLR:  rdata = 32'(latch_reg);
                    REG_MODE_LO:       rdata = mode_lo_reg;
                    REG_MODE_HI:       rdata = mode_hi_reg;
                    REG_MASK:          rdata = 32'(mask_reg);
                    REG_STATUS:        rdata = 32'(status_reg);
                    default:           rdata = '0;
                endcase
            end
            ACT_WRITE: begin
                unique case (item.reg_index)
                    REG_DIR:     dir_next     = wdata;
                    REG_SET:     latch_next   = latch_reg | wdata;
                    REG_CLR:     latch_next   = latch_reg & ~wdata;
                    REG_MODE_LO: mode_lo_next = item.write_data;
                    REG_MODE_HI: mode_hi_next = item.write_data;
                    REG_MASK:    mask_next    = wdata;
                    REG_STATUS:  status_next  = status_reg & ~wdata;
                    default:     ;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        result.read_data   = rdata;
        result.out_values  = 32'(latch_next & ~dir_next);
        result.out_enables = 32'(~dir_next & PIN_MASK);
        result.irq         = |(status_next & ~mask_next & valid_pins);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pin_count_reg <= CNT_W'(PIN_WIDTH);
            dir_reg       <= PIN_MASK;
            latch_reg     <= '0;
            mode_lo_reg   <= '0;
            mode_hi_reg   <= '0;
            mask_reg      <= PIN_MASK;
            status_reg    <= '0;
            prev_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                pin_count_reg <= cfg_wr_data;
            end
            if (accept) begin
                dir_reg     <= dir_next;
                latch_reg   <= latch_next;
                mode_lo_reg <= mode_lo_next;
                mode_hi_reg <= mode_hi_next;
                mask_reg    <= mask_next;
                status_reg  <= status_next;
                prev_reg    <= prev_next;
            end
        end
    end

endmodule

// File: rtl/gpioid_skid.sv
// ----------------------------------------------------------------------------
// gpioid_skid
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module gpioid_skid
    import gpioid_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic in_valid,
    input  out_t in_data,
    output logic in_ready,
    output logic out_valid,
    output out_t out_data,
    input  logic out_ready
);

    logic main_valid_reg, main_valid_next;
    logic skid_valid_reg, skid_valid_next;
    out_t main_reg, main_next;
    out_t skid_reg, skid_next;
    logic load;

    assign in_ready  = ~skid_valid_reg;
    assign load      = in_valid & ~skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (!main_valid_reg || out_ready) begin
            main_valid_next = skid_valid_reg | load;
            main_next       = skid_valid_reg ? skid_reg : in_data;
            skid_valid_next = 1'b0;
        end else if (load) begin
            skid_valid_next = 1'b1;
            skid_next       = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

// File: rtl/gpio_port_with_interrupt_detect.sv
// ----------------------------------------------------------------------------
// gpio_port_with_interrupt_detect
// 32-pin GPIO port with per-pin level/edge interrupt detection.
// ----------------------------------------------------------------------------
// Each input transfer is a pin sample tick, a bus read or a bus write and
// yields exactly one result transfer carrying read data, drive values, drive
// enables and irq as they stand after that transfer. One transfer is taken
// every clock while s_ready is high; its result is registered into the
// two-entry output buffer on acceptance, which keeps s_ready high while one
// result waits on m_ready. pin_count is written through cfg_wr_en/cfg_wr_data.
// ----------------------------------------------------------------------------
module gpio_port_with_interrupt_detect
    import gpioid_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [CNT_W-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_t              s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_t             m_data
);

    logic accept;
    out_t result;

    assign accept = s_valid & s_ready;

    gpioid_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .item        (s_data),
        .result      (result)
    );

    gpioid_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_data   (result),
        .in_ready  (s_ready),
        .out_valid (m_valid),
        .out_data  (m_data),
        .out_ready (m_ready)
    );

endmodule
